// ===== sv/atm_pkg.sv =====
// ============================================================================
// atm_pkg - shared types and constants of the alarm table matcher
// Beat structs, entry layout, configuration register map and FSM states.
// ============================================================================
`default_nettype none

package atm_pkg;

    // Item opcodes
    typedef enum logic [0:0] {
        OP_TICK  = 1'b0,
        OP_WRITE = 1'b1
    } opcode_t;

    // Alarm entry kinds
    typedef enum logic [1:0] {
        KIND_ONCE     = 2'd0,
        KIND_DAILY    = 2'd1,
        KIND_WORKDAYS = 2'd2,
        KIND_WEEKENDS = 2'd3
    } kind_t;

    // Result event kinds
    typedef enum logic [0:0] {
        EV_ALARM = 1'b0,
        EV_CHIME = 1'b1
    } event_t;

    // Configuration register indexes
    localparam int unsigned CFG_IDX_W = 3;
    localparam int unsigned CFG_DATA_W = 8;
    localparam logic [CFG_IDX_W-1:0] REG_HOUR_CHIME    = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_HALF_CHIME    = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_QUARTER_CHIME = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_CHIME_START   = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_CHIME_END     = 3'd4;

    // Register reset values
    localparam logic [4:0] CHIME_END_RESET = 5'd24;

    // Calendar constants
    localparam logic [2:0] WD_SUNDAY   = 3'd0;
    localparam logic [2:0] WD_SATURDAY = 3'd6;
    localparam logic [5:0] MIN_FULL    = 6'd0;
    localparam logic [5:0] MIN_QUARTER = 6'd15;
    localparam logic [5:0] MIN_HALF    = 6'd30;
    localparam logic [5:0] MIN_3QUART  = 6'd45;
    localparam logic [5:0] SEC_ZERO    = 6'd0;

    // Width of the entry_index field
    localparam int unsigned IDX_W = 3;

    // Input beat
    typedef struct packed {
        logic [0:0] opcode;
        logic [5:0] second;
        logic [5:0] minute;
        logic [4:0] hour;
        logic [2:0] weekday;
        logic [2:0] entry_index;
        logic [0:0] entry_active;
        logic [1:0] entry_kind;
        logic [4:0] entry_hour;
        logic [5:0] entry_minute;
        logic [7:0] entry_sound;
    } item_t;

    // Output beat
    typedef struct packed {
        logic [0:0] event_kind;
        logic [7:0] sound;
        logic [2:0] alarm_slot;
        logic [0:0] slot_disabled;
    } result_t;

    // Stored part of an entry (the active flag lives in flip-flops)
    typedef struct packed {
        logic [1:0] kind;
        logic [4:0] hour;
        logic [5:0] minute;
        logic [7:0] sound;
    } entry_t;

    // Chime configuration
    typedef struct packed {
        logic [7:0] hour_chime_sound;
        logic [7:0] half_chime_sound;
        logic [7:0] quarter_chime_sound;
        logic [4:0] chime_start_hour;
        logic [4:0] chime_end_hour;
    } cfg_t;

    // Controller states
    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN,
        ST_EMIT
    } state_t;

endpackage

`default_nettype wire

// ===== sv/atm_table.sv =====
// ============================================================================
// atm_table - alarm entry store
// Entry fields in a synchronous RAM (one write, one registered read per
// cycle); active flags in flip-flops so reset empties the table at once.
// ============================================================================
`default_nettype none

module atm_table #(
    parameter int unsigned SLOTS  = 8,
    parameter int unsigned SLOT_W = 3
) (
    input  wire logic               clk,
    input  wire logic               rst_n,
    // write port
    input  wire logic               wr_en,
    input  wire logic [SLOT_W-1:0]  wr_addr,
    input  wire logic               wr_active,
    input  wire atm_pkg::entry_t    wr_entry,
    // once-only clear
    input  wire logic               clr_en,
    input  wire logic [SLOT_W-1:0]  clr_addr,
    // read port, registered data in the cycle after rd_en
    input  wire logic               rd_en,
    input  wire logic [SLOT_W-1:0]  rd_addr,
    output atm_pkg::entry_t         rd_entry,
    // active flags
    output logic [SLOTS-1:0]        active
);

    atm_pkg::entry_t mem [SLOTS];
    atm_pkg::entry_t rd_entry_reg;
    logic [SLOTS-1:0] active_reg;

    // Entry RAM
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_entry;
        end
        if (rd_en)
        begin
            rd_entry_reg <= mem[rd_addr];
        end
    end

    // Active flags; write and clear never meet (write only while idle)
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            active_reg <= '0;
        end
        else if (wr_en)
        begin
            active_reg[wr_addr] <= wr_active;
        end
        else if (clr_en)
        begin
            active_reg[clr_addr] <= 1'b0;
        end
    end

    assign rd_entry = rd_entry_reg;
    assign active   = active_reg;

endmodule

`default_nettype wire

// ===== sv/atm_ctrl.sv =====
// ============================================================================
// atm_ctrl - scan sequencer and result stage
// Takes item beats, writes entries, walks the table one slot per cycle on a
// tick at second zero, picks alarm or chime and holds the result beat.
// ============================================================================
`default_nettype none

module atm_ctrl #(
    parameter int unsigned SLOTS  = 8,
    parameter int unsigned SLOT_W = 3
) (
    input  wire logic               clk,
    input  wire logic               rst_n,
    // item channel
    input  wire logic               item_valid,
    output logic                    item_ready,
    input  wire atm_pkg::item_t     item,
    // result channel
    output logic                    result_valid,
    input  wire logic               result_ready,
    output atm_pkg::result_t        result,
    // configuration
    input  wire atm_pkg::cfg_t      cfg,
    // table
    output logic                    wr_en,
    output logic [SLOT_W-1:0]       wr_addr,
    output logic                    wr_active,
    output atm_pkg::entry_t         wr_entry,
    output logic                    clr_en,
    output logic [SLOT_W-1:0]       clr_addr,
    output logic                    rd_en,
    output logic [SLOT_W-1:0]       rd_addr,
    input  wire atm_pkg::entry_t    rd_entry,
    input  wire logic [SLOTS-1:0]   active
);

    localparam logic [SLOT_W-1:0] LAST_SLOT = SLOT_W'(SLOTS - 1);
    localparam logic [6:0]        SLOTS_N   = 7'(SLOTS);

    atm_pkg::state_t  state_reg, state_next;
    logic [SLOT_W-1:0] cnt_reg, cnt_next;
    logic [5:0]        minute_reg, minute_next;
    logic [4:0]        hour_reg, hour_next;
    logic              weekend_reg, weekend_next;
    atm_pkg::result_t  res_reg, res_next;
    atm_pkg::result_t  out_reg, out_next;
    logic              out_valid_reg, out_valid_next;

    logic accept, is_write, in_range, start_scan;
    logic last, hit, kind_ok, chime_hit, in_window, out_free;
    logic [7:0] chime_snd;

    // Item decode
    assign item_ready = (state_reg == atm_pkg::ST_IDLE);
    assign accept     = item_valid && item_ready;
    assign is_write   = (item.opcode == atm_pkg::OP_WRITE);
    assign in_range   = {4'b0, item.entry_index} < SLOTS_N;
    assign start_scan = accept && !is_write && (item.second == atm_pkg::SEC_ZERO);

    // Slot match on the entry read last cycle
    assign last = (cnt_reg == LAST_SLOT);
    always_comb
    begin
        kind_ok = 1'b1;
        case (rd_entry.kind)
            atm_pkg::KIND_WORKDAYS: kind_ok = !weekend_reg;
            atm_pkg::KIND_WEEKENDS: kind_ok = weekend_reg;
            default:                kind_ok = 1'b1;
        endcase
    end
    assign hit = (state_reg == atm_pkg::ST_SCAN) && active[cnt_reg] &&
                 (rd_entry.hour == hour_reg) && (rd_entry.minute == minute_reg) && kind_ok;

    // Chime choice: full hour, then half, then quarters
    assign in_window = (hour_reg >= cfg.chime_start_hour) && (hour_reg < cfg.chime_end_hour);
    always_comb
    begin
        chime_hit = 1'b0;
        chime_snd = cfg.hour_chime_sound;
        if (cfg.hour_chime_sound != 8'd0 && minute_reg == atm_pkg::MIN_FULL)
        begin
            chime_hit = 1'b1;
            chime_snd = cfg.hour_chime_sound;
        end
        else if (cfg.half_chime_sound != 8'd0 && minute_reg == atm_pkg::MIN_HALF)
        begin
            chime_hit = 1'b1;
            chime_snd = cfg.half_chime_sound;
        end
        else if (cfg.quarter_chime_sound != 8'd0 &&
                 (minute_reg == atm_pkg::MIN_QUARTER || minute_reg == atm_pkg::MIN_3QUART))
        begin
            chime_hit = 1'b1;
            chime_snd = cfg.quarter_chime_sound;
        end
        chime_hit = chime_hit && in_window;
    end

    assign out_free = !out_valid_reg || result_ready;

    // Next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            atm_pkg::ST_IDLE:
            begin
                if (start_scan)
                begin
                    state_next = atm_pkg::ST_SCAN;
                end
            end
            atm_pkg::ST_SCAN:
            begin
                if (hit || (last && chime_hit))
                begin
                    state_next = atm_pkg::ST_EMIT;
                end
                else if (last)
                begin
                    state_next = atm_pkg::ST_IDLE;
                end
            end
            atm_pkg::ST_EMIT:
            begin
                if (out_free)
                begin
                    state_next = atm_pkg::ST_IDLE;
                end
            end
            default: state_next = atm_pkg::ST_IDLE;
        endcase
    end

    // Datapath and table control
    always_comb
    begin
        wr_en          = 1'b0;
        wr_addr        = SLOT_W'(item.entry_index);
        wr_active      = item.entry_active[0];
        wr_entry.kind   = item.entry_kind;
        wr_entry.hour   = item.entry_hour;
        wr_entry.minute = item.entry_minute;
        wr_entry.sound  = item.entry_sound;
        clr_en         = 1'b0;
        clr_addr       = cnt_reg;
        rd_en          = 1'b0;
        rd_addr        = SLOT_W'(cnt_reg + 1'b1);
        cnt_next       = cnt_reg;
        minute_next    = minute_reg;
        hour_next      = hour_reg;
        weekend_next   = weekend_reg;
        res_next       = res_reg;
        out_next       = out_reg;
        out_valid_next = out_valid_reg && !result_ready;

        unique case (state_reg)
            atm_pkg::ST_IDLE:
            begin
                wr_en = accept && is_write && in_range;
                if (start_scan)
                begin
                    rd_en        = 1'b1;
                    rd_addr      = '0;
                    cnt_next     = '0;
                    minute_next  = item.minute;
                    hour_next    = item.hour;
                    weekend_next = (item.weekday == atm_pkg::WD_SUNDAY) ||
                                   (item.weekday == atm_pkg::WD_SATURDAY);
                end
            end
            atm_pkg::ST_SCAN:
            begin
                if (hit)
                begin
                    clr_en                 = (rd_entry.kind == atm_pkg::KIND_ONCE);
                    res_next.event_kind    = atm_pkg::EV_ALARM;
                    res_next.sound         = rd_entry.sound;
                    res_next.alarm_slot    = 3'(cnt_reg);
                    res_next.slot_disabled = (rd_entry.kind == atm_pkg::KIND_ONCE);
                end
                else if (last)
                begin
                    res_next.event_kind    = atm_pkg::EV_CHIME;
                    res_next.sound         = chime_snd;
                    res_next.alarm_slot    = 3'd0;
                    res_next.slot_disabled = 1'b0;
                end
                else
                begin
                    rd_en    = 1'b1;
                    cnt_next = SLOT_W'(cnt_reg + 1'b1);
                end
            end
            atm_pkg::ST_EMIT:
            begin
                if (out_free)
                begin
                    out_next       = res_reg;
                    out_valid_next = 1'b1;
                end
            end
            default: ;
        endcase
    end

    // Control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= atm_pkg::ST_IDLE;
            cnt_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            cnt_reg       <= cnt_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        minute_reg  <= minute_next;
        hour_reg    <= hour_next;
        weekend_reg <= weekend_next;
        res_reg     <= res_next;
        out_reg     <= out_next;
    end

    assign result_valid = out_valid_reg;
    assign result       = out_reg;

endmodule

`default_nettype wire

// ===== sv/alarm_table_matcher_with_chime_unit.sv =====
// ============================================================================
// alarm_table_matcher_with_chime_unit - alarm table matcher with chime
// Keeps an alarm table, matches it against time ticks, issues events.
// ============================================================================
// Usage:
//   item channel (item_valid/item_ready/item) carries write beats, which store
//   one alarm entry, and tick beats with time of day and weekday.
//   result channel (result_valid/result_ready/result) carries at most one
//   event per tick: an alarm from the first matching slot, else a chime.
//   cfg_write/cfg_index/cfg_data set the chime sounds and window; idle only.
// Flow:
//   A write beat, or a tick whose second is not zero, needs no walk; the
//   next beat can be taken in the next cycle.
//   A tick at second zero walks the entry RAM one slot per cycle and stops at
//   the first firing slot (the last slot for a chime); an event then passes
//   through ST_EMIT into the output register before the next beat is taken.
// Reset: every slot inactive, chime sounds zero, window 0 to 24.
// Stall: the output register holds its beat until taken; ticks may still
//   be accepted and walked meanwhile, the first with an event waits in ST_EMIT.
// ============================================================================
`default_nettype none

module alarm_table_matcher_with_chime_unit #(
    parameter int unsigned ALARM_SLOTS = 8
) (
    input  wire logic                              clk,
    input  wire logic                              rst_n,
    input  wire logic                              item_valid,
    output logic                                   item_ready,
    input  wire atm_pkg::item_t                    item,
    output logic                                   result_valid,
    input  wire logic                              result_ready,
    output atm_pkg::result_t                       result,
    input  wire logic                              cfg_write,
    input  wire logic [atm_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  wire logic [atm_pkg::CFG_DATA_W-1:0]    cfg_data
);

    localparam int unsigned SLOT_W = (ALARM_SLOTS > 1) ? $clog2(ALARM_SLOTS) : 1;

    atm_pkg::cfg_t cfg_reg;

    logic                    wr_en, wr_active, clr_en, rd_en;
    logic [SLOT_W-1:0]       wr_addr, clr_addr, rd_addr;
    atm_pkg::entry_t         wr_entry, rd_entry;
    logic [ALARM_SLOTS-1:0]  active;

    // Configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.hour_chime_sound    <= 8'd0;
            cfg_reg.half_chime_sound    <= 8'd0;
            cfg_reg.quarter_chime_sound <= 8'd0;
            cfg_reg.chime_start_hour    <= 5'd0;
            cfg_reg.chime_end_hour      <= atm_pkg::CHIME_END_RESET;
        end
        else if (cfg_write)
        begin
            unique case (cfg_index)
                atm_pkg::REG_HOUR_CHIME:    cfg_reg.hour_chime_sound    <= cfg_data;
                atm_pkg::REG_HALF_CHIME:    cfg_reg.half_chime_sound    <= cfg_data;
                atm_pkg::REG_QUARTER_CHIME: cfg_reg.quarter_chime_sound <= cfg_data;
                atm_pkg::REG_CHIME_START:   cfg_reg.chime_start_hour    <= cfg_data[4:0];
                atm_pkg::REG_CHIME_END:     cfg_reg.chime_end_hour      <= cfg_data[4:0];
                default: ;
            endcase
        end
    end

    atm_table #(
        .SLOTS  (ALARM_SLOTS),
        .SLOT_W (SLOT_W)
    ) u_table (
        .clk       (clk),
        .rst_n     (rst_n),
        .wr_en     (wr_en),
        .wr_addr   (wr_addr),
        .wr_active (wr_active),
        .wr_entry  (wr_entry),
        .clr_en    (clr_en),
        .clr_addr  (clr_addr),
        .rd_en     (rd_en),
        .rd_addr   (rd_addr),
        .rd_entry  (rd_entry),
        .active    (active)
    );

    atm_ctrl #(
        .SLOTS  (ALARM_SLOTS),
        .SLOT_W (SLOT_W)
    ) u_ctrl (
        .clk          (clk),
        .rst_n        (rst_n),
        .item_valid   (item_valid),
        .item_ready   (item_ready),
        .item         (item),
        .result_valid (result_valid),
        .result_ready (result_ready),
        .result       (result),
        .cfg          (cfg_reg),
        .wr_en        (wr_en),
        .wr_addr      (wr_addr),
        .wr_active    (wr_active),
        .wr_entry     (wr_entry),
        .clr_en       (clr_en),
        .clr_addr     (clr_addr),
        .rd_en        (rd_en),
        .rd_addr      (rd_addr),
        .rd_entry     (rd_entry),
        .active       (active)
    );

    // Beats that need no walk leave the block ready next cycle
    a_quick_items: assert property (@(posedge clk) disable iff (!rst_n)
        item_valid && item_ready &&
        (item.opcode == atm_pkg::OP_WRITE || item.second != atm_pkg::SEC_ZERO)
        |=> item_ready)
        else $error("ready dropped after a write or non-zero-second tick");

    // A tick at second zero starts a walk
    a_scan_starts: assert property (@(posedge clk) disable iff (!rst_n)
        item_valid && item_ready &&
        item.opcode == atm_pkg::OP_TICK && item.second == atm_pkg::SEC_ZERO
        |=> !item_ready)
        else $error("tick at second zero did not start a walk");

    // Chime events carry no slot and never report a cleared slot
    a_chime_fields: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && result.event_kind == atm_pkg::EV_CHIME
        |-> result.alarm_slot == 3'd0 && result.slot_disabled == 1'b0)
        else $error("chime event with slot fields set");

endmodule

`default_nettype wire

// ===== tb/alarm_event_checker.sv =====
// ----------------------------------------------------------------------------
// alarm_event_checker - event predictor and checker for the alarm matcher
// Watches the item, result and configuration ports, keeps its own alarm table
// and chime settings, predicts the event of each accepted tick and compares
// every result beat field by field with the oldest predicted event.
// ----------------------------------------------------------------------------
module alarm_event_checker
    import atm_pkg::*;
#(
    parameter int unsigned ALARM_SLOTS = 8
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  item_valid,
    input  logic                  item_ready,
    input  item_t                 item,
    input  logic                  result_valid,
    input  logic                  result_ready,
    input  result_t               result,
    input  logic                  cfg_write,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data,
    output int                    failures,
    output int                    outstanding
);

    timeunit 1ns;
    timeprecision 1ps;

    // One alarm slot as the predictor holds it
    typedef struct packed {
        logic       active;
        kind_t      kind;
        logic [4:0] hour;
        logic [5:0] minute;
        logic [7:0] sound;
    } slot_t;

    slot_t      alarm_slots [ALARM_SLOTS];
    logic [7:0] hour_chime;
    logic [7:0] half_chime;
    logic [7:0] quarter_chime;
    logic [4:0] window_start;
    logic [4:0] window_end;
    result_t    pending_events [$];

    // Event caused by a tick beat; clears a once-only slot that fires
    function automatic bit tick_event(input item_t tick, output result_t ev);
        bit weekend;
        bit fired;
        weekend = (tick.weekday == WD_SUNDAY) || (tick.weekday == WD_SATURDAY);
        fired   = 1'b0;
        ev      = '0;
        if (tick.second != SEC_ZERO)
            return 1'b0;
        // first active slot whose time and day kind fit wins
        for (int s = 0; s < ALARM_SLOTS; s++)
        begin
            if (!fired && alarm_slots[s].active && alarm_slots[s].hour == tick.hour
                && alarm_slots[s].minute == tick.minute
                && !(alarm_slots[s].kind == KIND_WEEKENDS && !weekend)
                && !(alarm_slots[s].kind == KIND_WORKDAYS && weekend))
            begin
                fired            = 1'b1;
                ev.event_kind    = EV_ALARM;
                ev.sound         = alarm_slots[s].sound;
                ev.alarm_slot    = 3'(s);
                ev.slot_disabled = (alarm_slots[s].kind == KIND_ONCE);
                if (alarm_slots[s].kind == KIND_ONCE)
                    alarm_slots[s].active = 1'b0;
            end
        end
        if (fired)
            return 1'b1;
        // chimes only inside the window, full hour before half before quarter
        if (tick.hour >= window_start && tick.hour < window_end)
        begin
            ev.event_kind = EV_CHIME;
            if (hour_chime != 8'd0 && tick.minute == MIN_FULL)
            begin
                ev.sound = hour_chime;
                return 1'b1;
            end
            if (half_chime != 8'd0 && tick.minute == MIN_HALF)
            begin
                ev.sound = half_chime;
                return 1'b1;
            end
            if (quarter_chime != 8'd0
                && (tick.minute == MIN_QUARTER || tick.minute == MIN_3QUART))
            begin
                ev.sound = quarter_chime;
                return 1'b1;
            end
        end
        return 1'b0;
    endfunction

    function automatic void check_field(input string name, input int unsigned want,
                                        input int unsigned got);
        if (want != got)
        begin
            failures++;
            $error("%s expected %0d got %0d", name, want, got);
        end
    endfunction

    // Sample all ports at the rising edge
    always @(posedge clk)
    begin
        result_t want;
        result_t ev;
        if (!rst_n)
        begin
            for (int s = 0; s < ALARM_SLOTS; s++)
                alarm_slots[s] = '0;
            hour_chime    = '0;
            half_chime    = '0;
            quarter_chime = '0;
            window_start  = '0;
            window_end    = CHIME_END_RESET;
            pending_events.delete();
        end
        else
        begin
            // register writes; unknown indexes fall through
            if (cfg_write)
            begin
                case (cfg_index)
                    REG_HOUR_CHIME:    hour_chime    = cfg_data;
                    REG_HALF_CHIME:    half_chime    = cfg_data;
                    REG_QUARTER_CHIME: quarter_chime = cfg_data;
                    REG_CHIME_START:   window_start  = cfg_data[4:0];
                    REG_CHIME_END:     window_end    = cfg_data[4:0];
                    default: ;
                endcase
            end
            // result beat against the oldest predicted event
            if (result_valid && result_ready)
            begin
                if (pending_events.size() == 0)
                begin
                    failures++;
                    $error("unexpected result beat: event_kind %0d sound %0d slot %0d",
                           result.event_kind, result.sound, result.alarm_slot);
                end
                else
                begin
                    want = pending_events.pop_front();
                    check_field("event_kind", want.event_kind, result.event_kind);
                    check_field("sound", want.sound, result.sound);
                    check_field("alarm_slot", want.alarm_slot, result.alarm_slot);
                    check_field("slot_disabled", want.slot_disabled, result.slot_disabled);
                end
            end
            // item beat: store an entry or predict the tick's event
            if (item_valid && item_ready)
            begin
                if (item.opcode == OP_WRITE)
                begin
                    if (item.entry_index < ALARM_SLOTS)
                        alarm_slots[item.entry_index] = '{active: item.entry_active,
                                                          kind:   kind_t'(item.entry_kind),
                                                          hour:   item.entry_hour,
                                                          minute: item.entry_minute,
                                                          sound:  item.entry_sound};
                end
                else if (tick_event(item, ev))
                    pending_events = {pending_events, ev};
            end
        end
        outstanding = pending_events.size();
    end

endmodule

// ===== tb/alarm_table_matcher_with_chime_unit_test.sv =====
// ----------------------------------------------------------------------------
// alarm_table_matcher_with_chime_unit_test - test of the alarm matcher
// Drives directed and random entry writes and time ticks through several chime
// settings, with random gaps on both channels and one long result stall; the
// event checker predicts and compares, this module gives the verdict.
// ----------------------------------------------------------------------------
module alarm_table_matcher_with_chime_unit_test;

    timeunit 1ns;
    timeprecision 1ps;

    import atm_pkg::*;

    localparam int unsigned ALARM_SLOTS     = 8;
    localparam int unsigned ITEM_W          = $bits(item_t);
    localparam int unsigned PHASES          = 8;
    localparam int unsigned ITEMS_PER_PHASE = 228;
    localparam int unsigned SETTLE_CYCLES   = 2 * ALARM_SLOTS + 4;
    localparam int unsigned LONG_HOLD       = 300;
    localparam int unsigned TIMEOUT_NS      = 8_000_000;

    logic                  clk = 1'b0;
    logic                  rst_n = 1'b0;
    logic                  item_valid = 1'b0;
    logic                  item_ready;
    item_t                 item = '0;
    logic                  result_valid;
    logic                  result_ready = 1'b0;
    result_t               result;
    logic                  cfg_write = 1'b0;
    logic [CFG_IDX_W-1:0]  cfg_index = '0;
    logic [CFG_DATA_W-1:0] cfg_data = '0;
    int                    failures;
    int                    outstanding;

    // stimulus-side record of slot times, used to aim ticks at stored alarms
    logic [4:0] slot_hour [ALARM_SLOTS];
    logic [5:0] slot_minute [ALARM_SLOTS];

    bit tx_steady = 1'b0;
    bit rx_steady = 1'b0;
    bit hold_req = 1'b0;
    bit hold_served = 1'b0;

    alarm_table_matcher_with_chime_unit #(
        .ALARM_SLOTS(ALARM_SLOTS)
    ) dut (
        .clk(clk),
        .rst_n(rst_n),
        .item_valid(item_valid),
        .item_ready(item_ready),
        .item(item),
        .result_valid(result_valid),
        .result_ready(result_ready),
        .result(result),
        .cfg_write(cfg_write),
        .cfg_index(cfg_index),
        .cfg_data(cfg_data)
    );

    alarm_event_checker #(
        .ALARM_SLOTS(ALARM_SLOTS)
    ) event_check (
        .clk(clk),
        .rst_n(rst_n),
        .item_valid(item_valid),
        .item_ready(item_ready),
        .item(item),
        .result_valid(result_valid),
        .result_ready(result_ready),
        .result(result),
        .cfg_write(cfg_write),
        .cfg_index(cfg_index),
        .cfg_data(cfg_data),
        .failures(failures),
        .outstanding(outstanding)
    );

    always #5 clk = ~clk;

    // Mostly short gaps, now and then a long one
    function automatic int idle_span();
        int roll;
        roll = $urandom_range(99);
        if (roll < 65)
            return 0;
        if (roll < 93)
            return $urandom_range(3, 1);
        return $urandom_range(40, 10);
    endfunction

    function automatic logic [5:0] quarter_minute();
        case ($urandom_range(3))
            0: return MIN_FULL;
            1: return MIN_QUARTER;
            2: return MIN_HALF;
            default: return MIN_3QUART;
        endcase
    endfunction

    // Mostly second zero, the rest are ticks the block passes over
    function automatic logic [5:0] tick_second();
        return ($urandom_range(3) != 0) ? SEC_ZERO : 6'($urandom_range(63, 1));
    endfunction

    // Entry write beat; the tick fields carry noise
    function automatic item_t write_beat(input logic [2:0] slot, input logic active,
                                         input kind_t kind, input logic [4:0] hr,
                                         input logic [5:0] mn, input logic [7:0] snd);
        item_t b;
        b              = item_t'(ITEM_W'({$urandom, $urandom}));
        b.opcode       = OP_WRITE;
        b.entry_index  = slot;
        b.entry_active = active;
        b.entry_kind   = kind;
        b.entry_hour   = hr;
        b.entry_minute = mn;
        b.entry_sound  = snd;
        return b;
    endfunction

    // Tick beat; the entry fields carry noise
    function automatic item_t tick_beat(input logic [4:0] hr, input logic [5:0] mn,
                                        input logic [5:0] sec, input logic [2:0] wd);
        item_t b;
        b         = item_t'(ITEM_W'({$urandom, $urandom}));
        b.opcode  = OP_TICK;
        b.hour    = hr;
        b.minute  = mn;
        b.second  = sec;
        b.weekday = wd;
        return b;
    endfunction

    // Offer one beat after a random gap; returns at the falling edge after
    // acceptance with valid still high
    task automatic offer(input item_t beat);
        int gap;
        gap = tx_steady ? 0 : idle_span();
        if (gap > 0)
        begin
            item_valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        item       <= beat;
        item_valid <= 1'b1;
        if (beat.opcode == OP_WRITE)
        begin
            slot_hour[beat.entry_index]   = beat.entry_hour;
            slot_minute[beat.entry_index] = beat.entry_minute;
        end
        do @(posedge clk); while (!item_ready);
        @(negedge clk);
    endtask

    task automatic cfg_put(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
        cfg_write <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        @(negedge clk);
    endtask

    // All five registers, then a write to an unused index that must change nothing
    task automatic set_chimes(input logic [7:0] hour_snd, input logic [7:0] half_snd,
                              input logic [7:0] quarter_snd, input logic [7:0] first_hour,
                              input logic [7:0] end_hour);
        cfg_put(REG_HOUR_CHIME, hour_snd);
        cfg_put(REG_HALF_CHIME, half_snd);
        cfg_put(REG_QUARTER_CHIME, quarter_snd);
        cfg_put(REG_CHIME_START, first_hour);
        cfg_put(REG_CHIME_END, end_hour);
        cfg_put(CFG_IDX_W'(REG_CHIME_END + 1 + $urandom_range(2)), 8'($urandom));
        cfg_write <= 1'b0;
    endtask

    // Drain: no event pending, then let a last scan finish
    task automatic wait_idle();
        item_valid <= 1'b0;
        while (outstanding != 0)
            @(negedge clk);
        repeat (SETTLE_CYCLES) @(negedge clk);
    endtask

    // Result side: random stalls, one long hold when asked
    initial
    begin
        int span;
        forever
        begin
            @(negedge clk);
            if (hold_req && !hold_served)
            begin
                span        = LONG_HOLD;
                hold_served = 1'b1;
            end
            else
                span = rx_steady ? 0 : idle_span();
            if (span > 0)
            begin
                result_ready <= 1'b0;
                repeat (span) @(negedge clk);
            end
            result_ready <= 1'b1;
        end
    end

    initial
    begin
        #(TIMEOUT_NS);
        $display("alarm_table_matcher_with_chime_unit test failed");
        $finish;
    end

    // Stimulus
    initial
    begin
        item_t beat;
        int    pick;
        int    target;
        for (int s = 0; s < ALARM_SLOTS; s++)
        begin
            slot_hour[s]   = '0;
            slot_minute[s] = '0;
        end
        repeat (6) @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // directed: every kind, weekday edges, out-of-range times, all chimes
        set_chimes(8'h11, 8'h22, 8'h33, 8'd0, 8'd24);
        offer(write_beat(3'd0, 1'b1, KIND_ONCE, 5'd7, MIN_HALF, 8'hFF));
        offer(write_beat(3'd1, 1'b1, KIND_DAILY, 5'd7, MIN_HALF, 8'h01));
        offer(write_beat(3'd2, 1'b1, KIND_WORKDAYS, 5'd6, MIN_FULL, 8'h5A));
        offer(write_beat(3'd3, 1'b1, KIND_WEEKENDS, 5'd6, MIN_FULL, 8'hA5));
        offer(write_beat(3'd7, 1'b1, KIND_DAILY, 5'd31, 6'd63, 8'h80));
        offer(write_beat(3'd4, 1'b0, KIND_DAILY, 5'd12, MIN_FULL, 8'h77));
        offer(tick_beat(5'd7, MIN_HALF, SEC_ZERO, 3'd2));
        offer(tick_beat(5'd7, MIN_HALF, SEC_ZERO, 3'd2));
        offer(tick_beat(5'd7, MIN_HALF, 6'd59, 3'd2));
        offer(tick_beat(5'd6, MIN_FULL, SEC_ZERO, WD_SUNDAY));
        offer(tick_beat(5'd6, MIN_FULL, SEC_ZERO, WD_SATURDAY));
        offer(tick_beat(5'd6, MIN_FULL, SEC_ZERO, 3'd3));
        offer(tick_beat(5'd6, MIN_FULL, SEC_ZERO, 3'd7));
        offer(tick_beat(5'd31, 6'd63, SEC_ZERO, 3'd5));
        offer(tick_beat(5'd12, MIN_FULL, SEC_ZERO, 3'd1));
        offer(tick_beat(5'd12, MIN_HALF, SEC_ZERO, 3'd1));
        offer(tick_beat(5'd12, MIN_QUARTER, SEC_ZERO, 3'd1));
        offer(tick_beat(5'd12, MIN_3QUART, SEC_ZERO, 3'd1));
        offer(tick_beat(5'd12, 6'd10, SEC_ZERO, 3'd1));
        offer(tick_beat(5'd0, MIN_FULL, SEC_ZERO, 3'd4));
        offer(tick_beat(5'd23, MIN_3QUART, SEC_ZERO, 3'd4));
        offer(write_beat(3'd5, 1'b1, KIND_WORKDAYS, 5'd23, 6'd59, 8'h00));
        offer(tick_beat(5'd23, 6'd59, SEC_ZERO, WD_SATURDAY));
        offer(tick_beat(5'd23, 6'd59, SEC_ZERO, 3'd1));
        wait_idle();

        // random phases, each under its own chime setting, some with steady channels
        for (int phase = 0; phase < PHASES; phase++)
        begin
            case (phase)
                0: set_chimes(8'h01, 8'h80, 8'hFF, 8'd0, 8'd24);
                1: set_chimes(8'h00, 8'h00, 8'h00, 8'd0, 8'd24);
                2: set_chimes(8'hFF, 8'hFF, 8'hFF, 8'd24, 8'd24);
                3: set_chimes(8'($urandom), 8'($urandom), 8'($urandom), 8'd8, 8'd20);
                4: set_chimes(8'($urandom), 8'($urandom), 8'($urandom), 8'd20, 8'd8);
                5: set_chimes(8'($urandom), 8'($urandom), 8'($urandom), 8'd0, 8'd0);
                // upper bits dropped: window 5 to 31 lets hours past 23 chime
                6: set_chimes(8'($urandom), 8'($urandom), 8'($urandom), 8'hE5, 8'hFF);
                default: set_chimes(8'($urandom_range(255, 1)), 8'($urandom_range(255, 1)),
                                    8'($urandom_range(255, 1)), 8'($urandom_range(12)),
                                    8'($urandom_range(24, 12)));
            endcase
            tx_steady = (phase == 2) || (phase == 5) || (phase == 6);
            rx_steady = (phase == 2) || (phase == 4);
            if (phase == 5)
                hold_req = 1'b1;
            repeat (ITEMS_PER_PHASE)
            begin
                pick = $urandom_range(99);
                if (pick < 20)
                    beat = write_beat(3'($urandom_range(7)), $urandom_range(9) != 0,
                                      kind_t'($urandom_range(3)),
                                      ($urandom_range(9) != 0) ? 5'($urandom_range(23))
                                                               : 5'($urandom_range(31, 24)),
                                      $urandom_range(1) ? quarter_minute() : 6'($urandom),
                                      8'($urandom));
                else if (pick < 60)
                begin
                    // aim at a stored slot time
                    target = $urandom_range(ALARM_SLOTS - 1);
                    beat   = tick_beat(slot_hour[target], slot_minute[target], tick_second(),
                                       3'($urandom_range(7)));
                end
                else if (pick < 85)
                    beat = tick_beat(5'($urandom_range(31)), quarter_minute(), tick_second(),
                                     3'($urandom_range(7)));
                else
                    beat = tick_beat(5'($urandom), 6'($urandom), tick_second(), 3'($urandom));
                offer(beat);
            end
            wait_idle();
        end

        if (failures == 0 && outstanding == 0)
            $display("alarm_table_matcher_with_chime_unit test passed");
        else
            $display("alarm_table_matcher_with_chime_unit test failed");
        $finish;
    end

endmodule
